>>> rtl/int_to_base_n_ascii_unit_defines.svh
// Assertion macros for the integer to base-N text converter.
`ifndef INT_TO_BASE_N_ASCII_UNIT_DEFINES_SVH
`define INT_TO_BASE_N_ASCII_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define IBNA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IBNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ibna_pkg.sv
// Shared constants, microcode types and helpers for the base-N text converter.
`timescale 1ns / 1ps

package ibna_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DIV_BITS        = 8;   // quotient bits resolved per division cycle
  localparam int RADIX_W         = 5;
  localparam int CHAR_W          = 8;
  localparam int DIGIT_W         = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;  // 'A' - 10

  // Microprogram addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] ST_DIV   = 3'd1;
  localparam logic [PC_W-1:0] ST_STORE = 3'd2;
  localparam logic [PC_W-1:0] ST_RDSET = 3'd3;
  localparam logic [PC_W-1:0] ST_SIGN  = 3'd4;
  localparam logic [PC_W-1:0] ST_EMIT  = 3'd5;
  localparam logic [PC_W-1:0] ST_ERR   = 3'd6;
  localparam logic [PC_W-1:0] ST_SPARE = 3'd7;

  // Hold conditions: the step repeats while the condition is true
  localparam logic [1:0] H_NONE = 2'd0;
  localparam logic [1:0] H_IN   = 2'd1;
  localparam logic [1:0] H_OUT  = 2'd2;
  localparam logic [1:0] H_SIGN = 2'd3;

  // Branch conditions: true selects tgt_t, false selects tgt_f
  localparam logic [2:0] C_ALWAYS     = 3'd0;
  localparam logic [2:0] C_BAD_RADIX  = 3'd1;
  localparam logic [2:0] C_CHUNK_MORE = 3'd2;
  localparam logic [2:0] C_DIGIT_MORE = 3'd3;
  localparam logic [2:0] C_LAST       = 3'd4;

  typedef struct packed {
    logic            accept;
    logic            div;
    logic            store;
    logic            rdset;
    logic            emit_sign;
    logic            emit_digit;
    logic            emit_err;
    logic [1:0]      hold;
    logic [2:0]      cond;
    logic [PC_W-1:0] tgt_t;
    logic [PC_W-1:0] tgt_f;
  } ctrl_t;

  typedef struct packed {
    logic bad_radix;
    logic chunk_more;
    logic digit_more;
    logic last;
    logic neg;
    logic slot_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    return (d < 4'd10) ? (CHAR_ZERO + ext) : (CHAR_ALPHA + ext);
  endfunction

endpackage

>>> rtl/int_to_base_n_ascii_unit.sv
// Top level: signed integer to ASCII text in a configurable base, microcoded.
// One item at a time. With C = ceil(VALUE_WIDTH/8) (4 at 32 bits), each digit
// costs C divider passes; output stalls hold the sequencer.
// A bad radix gives a single error word in place of the text.
// Sync active-low reset: radix 10, sequencer idle, output empty; buffer not cleared.
`timescale 1ns / 1ps
`include "int_to_base_n_ascii_unit_defines.svh"

module int_to_base_n_ascii_unit #(
  parameter int VALUE_WIDTH = ibna_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ibna_pkg::RADIX_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [VALUE_WIDTH-1:0]       in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ibna_pkg::CHAR_W-1:0]  out_character,
  output logic                         out_is_last,
  output logic                         out_base_error
);
  import ibna_pkg::*;

  logic [PC_W-1:0] pc;
  logic            go;
  ctrl_t           ctrl;
  status_t         status;

  ibna_ucode_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  ibna_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .status   (status),
    .in_valid (in_valid),
    .pc       (pc),
    .go       (go)
  );

  ibna_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .go             (go),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_is_last    (out_is_last),
    .out_base_error (out_base_error)
  );

  assign in_ready  = ctrl.accept;
  assign cfg_ready = 1'b1;

  `IBNA_ASSERT_NOW(a_err_word_alone, out_valid && out_base_error, out_is_last && (out_character == CHAR_NONE), "error word must be last and carry no character")
  `IBNA_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, !in_ready, "sequencer stayed idle after accepting a word")
  `IBNA_ASSERT_NOW(a_idle_only_tail, in_ready && out_valid, out_is_last, "idle while a non-final character is pending")

endmodule

>>> rtl/ibna_ucode_rom.sv
// Microprogram store: one control word per sequencer step.
`timescale 1ns / 1ps

module ibna_ucode_rom (
  input  logic [ibna_pkg::PC_W-1:0] pc,
  output ibna_pkg::ctrl_t           ctrl
);
  import ibna_pkg::*;

  always_comb begin
    ctrl       = '0;
    ctrl.hold  = H_NONE;
    ctrl.cond  = C_ALWAYS;
    ctrl.tgt_t = ST_IDLE;
    ctrl.tgt_f = ST_IDLE;
    unique case (pc)
      ST_IDLE: begin
        ctrl.accept = 1'b1;
        ctrl.hold   = H_IN;
        ctrl.cond   = C_BAD_RADIX;
        ctrl.tgt_t  = ST_ERR;
        ctrl.tgt_f  = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div   = 1'b1;
        ctrl.cond  = C_CHUNK_MORE;
        ctrl.tgt_t = ST_DIV;
        ctrl.tgt_f = ST_STORE;
      end
      ST_STORE: begin
        ctrl.store = 1'b1;
        ctrl.cond  = C_DIGIT_MORE;
        ctrl.tgt_t = ST_DIV;
        ctrl.tgt_f = ST_RDSET;
      end
      ST_RDSET: begin
        ctrl.rdset = 1'b1;
        ctrl.tgt_t = ST_SIGN;
      end
      ST_SIGN: begin
        ctrl.emit_sign = 1'b1;
        ctrl.hold      = H_SIGN;
        ctrl.tgt_t     = ST_EMIT;
      end
      ST_EMIT: begin
        ctrl.emit_digit = 1'b1;
        ctrl.hold       = H_OUT;
        ctrl.cond       = C_LAST;
        ctrl.tgt_t      = ST_IDLE;
        ctrl.tgt_f      = ST_EMIT;
      end
      ST_ERR: begin
        ctrl.emit_err = 1'b1;
        ctrl.hold     = H_OUT;
        ctrl.tgt_t    = ST_IDLE;
      end
      ST_SPARE: begin
        ctrl.tgt_t = ST_IDLE;
      end
      default: begin
        ctrl.tgt_t = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ibna_seq.sv
// Step counter with hold and conditional branch evaluation.
`timescale 1ns / 1ps

module ibna_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ibna_pkg::ctrl_t           ctrl,
  input  ibna_pkg::status_t         status,
  input  logic                      in_valid,
  output logic [ibna_pkg::PC_W-1:0] pc,
  output logic                      go
);
  import ibna_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            hold;
  logic            cond_true;

  always_comb begin
    unique case (ctrl.hold)
      H_NONE:  hold = 1'b0;
      H_IN:    hold = !in_valid;
      H_OUT:   hold = !status.slot_free;
      H_SIGN:  hold = status.neg && !status.slot_free;
      default: hold = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:     cond_true = 1'b1;
      C_BAD_RADIX:  cond_true = status.bad_radix;
      C_CHUNK_MORE: cond_true = status.chunk_more;
      C_DIGIT_MORE: cond_true = status.digit_more;
      C_LAST:       cond_true = status.last;
      default:      cond_true = 1'b1;
    endcase
  end

  assign go     = !hold;
  assign pc_nxt = hold ? pc_r : (cond_true ? ctrl.tgt_t : ctrl.tgt_f);
  assign pc     = pc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/ibna_dp.sv
// Datapath: radix register, chunked divider, digit buffer and output register.
`timescale 1ns / 1ps

module ibna_dp #(
  parameter int VALUE_WIDTH = ibna_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ibna_pkg::ctrl_t              ctrl,
  input  logic                         go,
  output ibna_pkg::status_t            status,
  input  logic                         cfg_valid,
  input  logic [ibna_pkg::RADIX_W-1:0] cfg_data,
  input  logic [VALUE_WIDTH-1:0]       in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ibna_pkg::CHAR_W-1:0]  out_character,
  output logic                         out_is_last,
  output logic                         out_base_error
);
  import ibna_pkg::*;

  localparam int DIV_CHUNKS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_W      = DIV_CHUNKS * DIV_BITS;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;
  localparam int IDX_W      = $clog2(VALUE_WIDTH);
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  logic [RADIX_W-1:0] radix_r;
  logic [PAD_W-1:0]   mag_r;
  logic [RADIX_W-1:0] rem_r;
  logic [CHUNK_W-1:0] chunk_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               neg_r;
  logic [IDX_W-1:0]   emit_idx_r;
  logic [IDX_W-1:0]   emit_idx_nxt;
  logic [DIGIT_W-1:0] rd_r;
  logic [DIGIT_W-1:0] digit_mem [VALUE_WIDTH];

  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;
  logic               out_err_r;

  logic [PAD_W-1:0]       div_quot;
  logic [RADIX_W-1:0]     div_rem;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [CNT_W-1:0]       cnt_inc;
  logic [CNT_W-1:0]       cnt_dec;
  logic                   slot_free;
  logic                   acc_fire;
  logic                   div_fire;
  logic                   store_fire;
  logic                   rdset_fire;
  logic                   sign_fire;
  logic                   digit_fire;
  logic                   err_fire;

  assign acc_fire   = go && ctrl.accept;
  assign div_fire   = go && ctrl.div;
  assign store_fire = go && ctrl.store;
  assign rdset_fire = go && ctrl.rdset;
  assign sign_fire  = go && ctrl.emit_sign && neg_r;
  assign digit_fire = go && ctrl.emit_digit;
  assign err_fire   = go && ctrl.emit_err;

  assign slot_free = !out_valid_r || out_ready;
  assign cnt_inc   = cnt_r + 1'b1;
  assign cnt_dec   = cnt_r - 1'b1;
  assign mag_in    = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  // DIV_BITS steps of restoring division; dividend shifts out, quotient shifts in
  always_comb begin : div_chunk
    logic [RADIX_W-1:0] r;
    logic [PAD_W-1:0]   q;
    r = rem_r;
    q = mag_r;
    for (int j = 0; j < DIV_BITS; j++) begin
      r = {r[RADIX_W-2:0], q[PAD_W-1]};
      q = {q[PAD_W-2:0], 1'b0};
      if (r >= radix_r) begin
        r    = r - radix_r;
        q[0] = 1'b1;
      end
    end
    div_rem  = r;
    div_quot = q;
  end

  assign status.bad_radix  = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
  assign status.chunk_more = chunk_r != CHUNK_W'(DIV_CHUNKS - 1);
  assign status.digit_more = (mag_r != '0) && (cnt_inc < CNT_W'(VALUE_WIDTH));
  assign status.last       = emit_idx_r == '0;
  assign status.neg        = neg_r;
  assign status.slot_free  = slot_free;

  always_comb begin
    emit_idx_nxt = emit_idx_r;
    if (rdset_fire) begin
      emit_idx_nxt = cnt_dec[IDX_W-1:0];
    end else if (digit_fire) begin
      emit_idx_nxt = emit_idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r      <= '0;
      rem_r      <= '0;
      chunk_r    <= '0;
      cnt_r      <= '0;
      neg_r      <= 1'b0;
      emit_idx_r <= '0;
    end else begin
      emit_idx_r <= emit_idx_nxt;
      if (acc_fire) begin
        mag_r   <= PAD_W'(mag_in);
        rem_r   <= '0;
        chunk_r <= '0;
        cnt_r   <= '0;
        neg_r   <= in_value[VALUE_WIDTH-1];
      end else if (div_fire) begin
        mag_r   <= div_quot;
        rem_r   <= div_rem;
        chunk_r <= status.chunk_more ? CHUNK_W'(chunk_r + 1'b1) : '0;
      end else if (store_fire) begin
        rem_r <= '0;
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_fire) begin
      digit_mem[cnt_r[IDX_W-1:0]] <= rem_r[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= digit_mem[emit_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (err_fire || sign_fire || digit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (err_fire) begin
      out_char_r <= CHAR_NONE;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end else if (sign_fire) begin
      out_char_r <= CHAR_MINUS;
      out_last_r <= 1'b0;
      out_err_r  <= 1'b0;
    end else if (digit_fire) begin
      out_char_r <= digit_char(rd_r);
      out_last_r <= status.last;
      out_err_r  <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_is_last    = out_last_r;
  assign out_base_error = out_err_r;

endmodule

>>> tb/sv/int_to_base_n_ascii_unit_tb.sv
// Testbench for the integer to base-N text converter: predictor, driver and monitor.
`timescale 1ns / 1ps

module int_to_base_n_ascii_unit_tb;
  import ibna_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic              base_error;
  } text_word_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int NUM_SWEEPS     = 19;

  localparam logic [31:0] EDGE_VALUES [16] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0009,
    32'h0000_000A, 32'hFFFF_FFF6, 32'h0000_0063, 32'h0000_0064,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h3B9A_CA00,
    32'hC465_3601, 32'h075B_CD15, 32'h5555_5555, 32'hAAAA_AAAA
  };

  localparam logic [RADIX_W-1:0] SWEEP_RADIX [NUM_SWEEPS] = '{
    5'd10, 5'd16, 5'd2, 5'd17, 5'd7, 5'd31, 5'd1, 5'd8, 5'd3, 5'd13,
    5'd0, 5'd5, 5'd12, 5'd9, 5'd4, 5'd11, 5'd6, 5'd14, 5'd15
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [RADIX_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  out_character;
  logic               out_is_last;
  logic               out_base_error;

  logic               in_fire_q = 1'b0;
  logic               cfg_fire_q = 1'b0;
  logic [RADIX_W-1:0] radix_model = RADIX_RESET;
  logic [31:0]        value_backlog [$];
  text_word_t         expected_chars [$];
  int                 queued_count = 0;
  int                 accepted_count = 0;
  int                 chars_seen = 0;
  int                 base_errors_seen = 0;
  int                 radix_settings = 1;
  int                 errors = 0;
  int                 stall_cycles = 0;
  int unsigned        send_gap_pct = 0;
  int unsigned        recv_stall_pct = 0;

  int_to_base_n_ascii_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_is_last    (out_is_last),
    .out_base_error (out_base_error)
  );

  always #1 clk = ~clk;

  // Expected text of one value in the current radix, most significant first.
  function automatic void predict_text(input logic [31:0] v);
    logic [31:0]       mag;
    logic [DIGIT_W-1:0] digs [32];
    logic [CHAR_W-1:0] glyph;
    int                n;
    int                i;
    int unsigned       base;
    if (radix_model < RADIX_MIN || radix_model > RADIX_MAX) begin
      expected_chars.push_back('{character: CHAR_NONE, is_last: 1'b1, base_error: 1'b1});
      return;
    end
    base = 32'(radix_model);
    mag = v[31] ? (~v + 32'd1) : v;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0);
    if (v[31])
      expected_chars.push_back('{character: CHAR_MINUS, is_last: 1'b0, base_error: 1'b0});
    for (i = n - 1; i >= 0; i--) begin
      glyph = (digs[i] < 4'd10) ? CHAR_ZERO + CHAR_W'(digs[i])
                                : 8'h41 + CHAR_W'(digs[i]) - 8'd10;
      expected_chars.push_back('{character: glyph, is_last: (i == 0), base_error: 1'b0});
    end
  endfunction

  function automatic logic [31:0] draw_value(input logic [RADIX_W-1:0] r);
    longint unsigned p;
    int unsigned     base;
    int unsigned     k;
    int unsigned     j;
    logic [31:0]     v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2: v = $urandom_range(0, 300);
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      4: begin
        base = (r >= RADIX_MIN && r <= RADIX_MAX) ? 32'(r) : 32'd10;
        p = 1;
        k = $urandom_range(1, 31);
        for (j = 0; j < k && p * base <= 64'h8000_0000; j++)
          p = p * base;
        v = 32'(p + $urandom_range(0, 2) - 1);
      end
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000)
      v = -v;
    return v;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10)
      $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic queue_value(input logic [31:0] v);
    value_backlog.push_back(v);
    queued_count++;
  endtask

  // Hold off until every queued word is taken and all text has come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || expected_chars.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(negedge clk);
    while (!cfg_fire_q);
    cfg_valid <= 1'b0;
    radix_settings++;
  endtask

  task automatic set_idle(input idle_mode_t mode);
    send_gap_pct   = (mode == IDLE_SEND) ? 58 : (mode == IDLE_BOTH) ? 12 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 58 : (mode == IDLE_BOTH) ? 12 : 0;
  endtask

  // Driver: source side and sink ready, both changed on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (value_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_value <= value_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: checks output words, predicts on accepted input words.
  always @(posedge clk) begin
    text_word_t want;
    in_fire_q  <= rst_n && in_valid && in_ready;
    cfg_fire_q <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (out_base_error) base_errors_seen++;
        if (expected_chars.size() == 0) begin
          flag_error($sformatf("unexpected word char=%02h last=%0b err=%0b",
                               out_character, out_is_last, out_base_error));
        end else begin
          want = expected_chars.pop_front();
          if (out_character !== want.character || out_is_last !== want.is_last ||
              out_base_error !== want.base_error)
            flag_error($sformatf("exp char=%02h last=%0b err=%0b, got char=%02h last=%0b err=%0b",
                                 want.character, want.is_last, want.base_error,
                                 out_character, out_is_last, out_base_error));
        end
      end
      if (in_valid && in_ready) begin
        predict_text(in_value);
        accepted_count++;
      end
      if (cfg_valid && cfg_ready)
        radix_model = cfg_data;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int i;
    int count;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset radix, then the narrowest and widest bases and a bad one
    set_idle(IDLE_NONE);
    foreach (EDGE_VALUES[i]) queue_value(EDGE_VALUES[i]);
    wait_idle();
    write_radix(5'd2);
    queue_value(32'h8000_0000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'h0000_0000);
    wait_idle();
    write_radix(5'd16);
    queue_value(32'hDEAD_BEEF);
    queue_value(32'h0123_ABCD);
    wait_idle();
    write_radix(5'd0);
    queue_value(32'h0000_0005);
    queue_value(32'hFFFF_FFFB);
    wait_idle();

    for (p = 0; p < NUM_SWEEPS; p++) begin
      write_radix(SWEEP_RADIX[p]);
      set_idle(idle_mode_t'(p % 4));
      count = (SWEEP_RADIX[p] >= RADIX_MIN && SWEEP_RADIX[p] <= RADIX_MAX) ? 18 : 6;
      for (i = 0; i < count; i++) begin
        queue_value(draw_value(SWEEP_RADIX[p]));
        if (i == count / 2 - 1) wait_idle();
      end
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (expected_chars.size() != 0)
      flag_error($sformatf("%0d expected words never arrived", expected_chars.size()));
    $display("Converted %0d values under %0d radix settings (bad bases included),",
             accepted_count, radix_settings);
    $display("checked %0d output words, %0d of them base errors; %0d mismatches",
             chars_seen, base_errors_seen, errors);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
